/* hdl/pressure_trend_zscore_core_defines.svh */
// Assertion macros used by the checker file of the pressure trend core
`ifndef PRESSURE_TREND_ZSCORE_CORE_DEFINES_SVH
`define PRESSURE_TREND_ZSCORE_CORE_DEFINES_SVH

// Clocked assertion, quiet while reset is held
`define PTZ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also watches the reset cycles
`define PTZ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/ptz_pkg.sv */
// Shared constants, types and register codes of the pressure trend core
`default_nettype none
package ptz_pkg;

  localparam int DEPTH      = 1024;
  localparam int AW         = $clog2(DEPTH);
  localparam int FW         = $clog2(DEPTH + 1);
  localparam int SAMPLE_W   = 17;
  localparam int SQ_W       = 2 * SAMPLE_W;
  localparam int C1_W       = 18;
  localparam int R6_W       = 16;
  localparam int Z_W        = 16;
  localparam int SUM_W      = 28;
  localparam int SQS_W      = 45;
  localparam int LAG_W      = 10;
  localparam int THR_W      = 16;
  localparam int PROD_W     = 56;
  localparam int MULB_W     = 28;
  localparam int WIDE_W     = 72;
  localparam int QUO_W      = 31;
  localparam int RAD_W      = 32;
  localparam int ROOT_W     = 16;
  localparam int CNT_W      = 5;
  localparam int MUL_STEPS  = 28;
  localparam int DIV_STEPS  = 31;
  localparam int SQRT_STEPS = 16;
  localparam int DIV6_STEPS = 17;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SQ_W-1:0]     sq_t;
  typedef logic [AW-1:0]       addr_t;
  typedef logic [FW-1:0]       fill_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [SQS_W-1:0]    sqs_t;
  typedef logic [LAG_W-1:0]    lag_t;
  typedef logic [THR_W-1:0]    thr_t;
  typedef logic [PROD_W-1:0]   prod_t;
  typedef logic [MULB_W-1:0]   mulb_t;
  typedef logic [WIDE_W-1:0]   wide_t;
  typedef logic [QUO_W-1:0]    quo_t;
  typedef logic [RAD_W-1:0]    rad_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [APB_DW-1:0]   apb_data_t;

  // Register indexes on the configuration port (byte address / 4)
  localparam logic [1:0] REG_LAG_1H   = 2'd0;
  localparam logic [1:0] REG_LAG_6H   = 2'd1;
  localparam logic [1:0] REG_DROP_THR = 2'd2;

  localparam lag_t LAG_1H_RST   = 10'd60;
  localparam lag_t LAG_6H_RST   = 10'd360;
  localparam thr_t DROP_THR_RST = 16'd150;

endpackage
`default_nettype wire

/* hdl/ptz_if.sv */
// Valid/ready channel interfaces for samples and results
`default_nettype none
interface ptz_in_if;
  logic                         valid;
  logic                         ready;
  logic [ptz_pkg::SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface ptz_out_if;
  logic                             valid;
  logic                             ready;
  logic [ptz_pkg::SAMPLE_W-1:0]     pressure_now;
  logic signed [ptz_pkg::C1_W-1:0]  change_1h;
  logic signed [ptz_pkg::R6_W-1:0]  rate_6h;
  logic signed [ptz_pkg::Z_W-1:0]   zscore;
  logic                             drop_flag;
  modport source (output valid, output pressure_now, output change_1h, output rate_6h,
                  output zscore, output drop_flag, input ready);
  modport sink   (input valid, input pressure_now, input change_1h, input rate_6h,
                  input zscore, input drop_flag, output ready);
endinterface
`default_nettype wire

/* hdl/ptz_ram.sv */
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module ptz_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write one word and register one read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

/* hdl/pressure_trend_zscore_core.sv */
// Pressure trend core: hourly change, six-hour rate, window z-score and drop alert
// One sample is taken at a time. Once its beat is accepted, its result is worked out by
// three sample-store reads, three 28-step shift-add multiplier passes (n*Q, S*S, then
// the squared deviation), a 31-step restoring divider and a 16-step square root. A new
// sample is accepted as soon as the previous result sits in the output register, even
// while that result still waits to be taken. The sample store is a 1024-entry RAM with
// no clearing pass: reads are guarded by the fill count.
// Registers: lag_1h at 0x0, lag_6h at 0x4, drop_threshold at 0x8.
`default_nettype none
module pressure_trend_zscore_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ptz_in_if.sink                              in_ch,
  ptz_out_if.source                           out_ch,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [ptz_pkg::APB_AW-1:0]     cfg_paddr,
  input  wire logic [ptz_pkg::APB_DW-1:0]     cfg_pwdata,
  output logic      [ptz_pkg::APB_DW-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_RD_OLD  = 4'd1;
  localparam logic [3:0] ST_RD_L1   = 4'd2;
  localparam logic [3:0] ST_RD_L6   = 4'd3;
  localparam logic [3:0] ST_PREP    = 4'd4;
  localparam logic [3:0] ST_MUL_NQ  = 4'd5;
  localparam logic [3:0] ST_MUL_SS  = 4'd6;
  localparam logic [3:0] ST_MUL_MM  = 4'd7;
  localparam logic [3:0] ST_DIV_CHK = 4'd8;
  localparam logic [3:0] ST_DIV     = 4'd9;
  localparam logic [3:0] ST_SQRT    = 4'd10;
  localparam logic [3:0] ST_DONE    = 4'd11;

  logic [3:0] state_r, state_nxt;

  // configuration
  ptz_pkg::lag_t lag1_r, lag6_r;
  ptz_pkg::thr_t thr_r;

  // window state
  ptz_pkg::addr_t wp_r;
  ptz_pkg::fill_t fill_r;
  ptz_pkg::sum_t  sum_r;
  ptz_pkg::sqs_t  sqs_r;

  // per-sample working registers
  ptz_pkg::sample_t x_r, old_r, past1_r;
  ptz_pkg::sq_t     xsq_r, oldsq_r;
  logic [ptz_pkg::C1_W-1:0] c1_r;
  logic                     drop_r, neg6_r;
  ptz_pkg::sample_t         dv6_r;
  logic [2:0]               rem6_r;
  logic [ptz_pkg::R6_W-1:0] qu6_r;
  ptz_pkg::fill_t           n_r;
  logic                     zzero_r, zneg_r;
  ptz_pkg::prod_t           ma_r, acc_r, p_r, d_r, rem_r;
  ptz_pkg::mulb_t           mb_r;
  ptz_pkg::cnt_t            cnt_r;
  ptz_pkg::wide_t           a_r;
  ptz_pkg::quo_t            quo_r;
  ptz_pkg::rad_t            op_r, res_r, one_r;
  logic [ptz_pkg::Z_W-1:0]  zres_r;

  // output register
  logic                     ov_r, o_drop_r;
  ptz_pkg::sample_t         o_now_r;
  logic [ptz_pkg::C1_W-1:0] o_c1_r;
  logic [ptz_pkg::R6_W-1:0] o_r6_r;
  logic [ptz_pkg::Z_W-1:0]  o_z_r;

  // sample store
  ptz_pkg::addr_t   raddr;
  ptz_pkg::sample_t rdata;
  logic             mem_we;

  ptz_ram #(
    .WIDTH (ptz_pkg::SAMPLE_W),
    .DEPTH (ptz_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wp_r),
    .wdata (x_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic in_acc, out_load;
  assign in_acc   = in_ch.valid && (state_r == ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!ov_r || out_ch.ready);
  assign mem_we   = (state_r == ST_RD_L6);

  // Pick the read address: oldest entry, then the two lagged entries
  always_comb begin
    case (state_r)
      ST_RD_OLD: raddr = ptz_pkg::addr_t'(wp_r - ptz_pkg::addr_t'(lag1_r));
      ST_RD_L1:  raddr = ptz_pkg::addr_t'(wp_r - ptz_pkg::addr_t'(lag6_r));
      default:   raddr = wp_r;
    endcase
  end

  // Window update and lag differences, taken in the write cycle
  logic                     full;
  ptz_pkg::fill_t           fill_new;
  logic                     v1, v6;
  logic [ptz_pkg::C1_W-1:0] diff1, diff6, c1, d6;
  ptz_pkg::sample_t         mag6;
  logic [ptz_pkg::C1_W:0]   drop_sum;

  always_comb begin
    full     = (fill_r == ptz_pkg::fill_t'(ptz_pkg::DEPTH));
    fill_new = full ? fill_r : ptz_pkg::fill_t'(fill_r + 1'b1);
    v1       = (lag1_r != '0) && (ptz_pkg::fill_t'(lag1_r) < fill_new);
    v6       = (lag6_r != '0) && (ptz_pkg::fill_t'(lag6_r) < fill_new);
    diff1    = {1'b0, x_r} - {1'b0, past1_r};
    diff6    = {1'b0, x_r} - {1'b0, rdata};
    c1       = v1 ? diff1 : '0;
    d6       = v6 ? diff6 : '0;
    mag6     = d6[ptz_pkg::C1_W-1] ? ptz_pkg::sample_t'(-d6) : d6[ptz_pkg::SAMPLE_W-1:0];
    drop_sum = {c1[ptz_pkg::C1_W-1], c1} + {3'b000, thr_r};
  end

  // Deviation of the newest sample from the window mean, scaled by n
  logic [ptz_pkg::SUM_W-1:0] nx, zmag;
  logic                      zneg;
  always_comb begin
    nx   = ptz_pkg::sum_t'(n_r) * ptz_pkg::sum_t'(x_r);
    zneg = nx < sum_r;
    zmag = zneg ? (sum_r - nx) : (nx - sum_r);
  end

  // One shift-add multiplier step, one divide-by-six step
  ptz_pkg::prod_t acc_nxt;
  logic           mul_last;
  logic [3:0]     t6;
  logic           ge6;
  always_comb begin
    acc_nxt  = acc_r + (mb_r[0] ? ma_r : '0);
    mul_last = (cnt_r == ptz_pkg::cnt_t'(ptz_pkg::MUL_STEPS - 1));
    t6       = {rem6_r, dv6_r[ptz_pkg::SAMPLE_W-1]};
    ge6      = (t6 >= 4'd6);
  end

  // One restoring division step and one square-root step
  logic [ptz_pkg::PROD_W:0] dt;
  logic                     dge;
  ptz_pkg::prod_t           rem_nxt;
  ptz_pkg::quo_t            quo_nxt;
  ptz_pkg::rad_t            trial, res_nxt;
  logic                     sge, ovf;
  logic [ptz_pkg::Z_W:0]    root, lim, qcap;
  logic [ptz_pkg::Z_W-1:0]  zval;
  always_comb begin
    dt      = {rem_r, a_r[ptz_pkg::QUO_W-1]};
    dge     = dt >= {1'b0, d_r};
    rem_nxt = dge ? ptz_pkg::prod_t'(dt - {1'b0, d_r}) : dt[ptz_pkg::PROD_W-1:0];
    quo_nxt = {quo_r[ptz_pkg::QUO_W-2:0], dge};
    ovf     = ptz_pkg::prod_t'(a_r[ptz_pkg::WIDE_W-1:ptz_pkg::QUO_W]) >= d_r;
    trial   = res_r + one_r;
    sge     = op_r >= trial;
    res_nxt = sge ? ((res_r >> 1) + one_r) : (res_r >> 1);
    root    = {1'b0, res_nxt[ptz_pkg::ROOT_W-1:0]};
    lim     = zneg_r ? 17'd32768 : 17'd32767;
    qcap    = (root > lim) ? lim : root;
    zval    = zneg_r ? ptz_pkg::Z_W'(-qcap) : qcap[ptz_pkg::Z_W-1:0];
  end

  // Sequence one sample through reads, multiplier, divider and root
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_acc) state_nxt = ST_RD_OLD;
      ST_RD_OLD:  state_nxt = ST_RD_L1;
      ST_RD_L1:   state_nxt = ST_RD_L6;
      ST_RD_L6:   state_nxt = ST_PREP;
      ST_PREP:    state_nxt = ST_MUL_NQ;
      ST_MUL_NQ:  if (mul_last) state_nxt = ST_MUL_SS;
      ST_MUL_SS:  if (mul_last) state_nxt = ST_MUL_MM;
      ST_MUL_MM:  if (mul_last) state_nxt = ST_DIV_CHK;
      ST_DIV_CHK: begin
        if (zzero_r || d_r == '0) begin
          state_nxt = ST_DONE;
        end else if (ovf) begin
          state_nxt = ST_SQRT;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV:     if (cnt_r == ptz_pkg::cnt_t'(ptz_pkg::DIV_STEPS - 1)) state_nxt = ST_SQRT;
      ST_SQRT:    if (cnt_r == ptz_pkg::cnt_t'(ptz_pkg::SQRT_STEPS - 1)) state_nxt = ST_DONE;
      ST_DONE:    if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Control state, window state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      fill_r  <= '0;
      sum_r   <= '0;
      sqs_r   <= '0;
      ov_r    <= 1'b0;
      lag1_r  <= ptz_pkg::LAG_1H_RST;
      lag6_r  <= ptz_pkg::LAG_6H_RST;
      thr_r   <= ptz_pkg::DROP_THR_RST;
    end else begin
      state_r <= state_nxt;
      if (mem_we) begin
        wp_r   <= ptz_pkg::addr_t'(wp_r + 1'b1);
        fill_r <= fill_new;
        sum_r  <= sum_r - (full ? ptz_pkg::sum_t'(old_r) : '0) + ptz_pkg::sum_t'(x_r);
        sqs_r  <= sqs_r - (full ? ptz_pkg::sqs_t'(oldsq_r) : '0) + ptz_pkg::sqs_t'(xsq_r);
      end
      if (out_load) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (cfg_paddr[3:2])
          ptz_pkg::REG_LAG_1H:   lag1_r <= cfg_pwdata[ptz_pkg::LAG_W-1:0];
          ptz_pkg::REG_LAG_6H:   lag6_r <= cfg_pwdata[ptz_pkg::LAG_W-1:0];
          ptz_pkg::REG_DROP_THR: thr_r  <= cfg_pwdata[ptz_pkg::THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers, advanced per state
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          x_r   <= in_ch.sample;
          xsq_r <= in_ch.sample * in_ch.sample;
        end
      end
      ST_RD_OLD: old_r <= rdata;
      ST_RD_L1: begin
        past1_r <= rdata;
        oldsq_r <= old_r * old_r;
      end
      ST_RD_L6: begin
        c1_r   <= c1;
        drop_r <= drop_sum[ptz_pkg::C1_W];
        neg6_r <= d6[ptz_pkg::C1_W-1];
        dv6_r  <= mag6;
        rem6_r <= '0;
        qu6_r  <= '0;
        n_r    <= fill_new;
      end
      ST_PREP: begin
        zzero_r <= (n_r < ptz_pkg::fill_t'(2));
        zneg_r  <= zneg;
        p_r     <= ptz_pkg::prod_t'(zmag);
        ma_r    <= ptz_pkg::prod_t'(sqs_r);
        mb_r    <= ptz_pkg::mulb_t'(n_r);
        acc_r   <= '0;
        cnt_r   <= '0;
      end
      ST_MUL_NQ, ST_MUL_SS, ST_MUL_MM: begin
        // six-hour divide runs alongside the first pass
        if (state_r == ST_MUL_NQ && cnt_r < ptz_pkg::cnt_t'(ptz_pkg::DIV6_STEPS)) begin
          rem6_r <= ge6 ? 3'(t6 - 4'd6) : t6[2:0];
          qu6_r  <= {qu6_r[ptz_pkg::R6_W-2:0], ge6};
          dv6_r  <= {dv6_r[ptz_pkg::SAMPLE_W-2:0], 1'b0};
        end
        if (mul_last) begin
          acc_r <= '0;
          cnt_r <= '0;
          case (state_r)
            ST_MUL_NQ: begin
              d_r  <= acc_nxt;
              ma_r <= ptz_pkg::prod_t'(sum_r);
              mb_r <= ptz_pkg::mulb_t'(sum_r);
            end
            ST_MUL_SS: begin
              d_r  <= d_r - acc_nxt;
              ma_r <= p_r;
              mb_r <= ptz_pkg::mulb_t'(p_r);
            end
            default: a_r <= {acc_nxt, 16'h0000};
          endcase
        end else begin
          acc_r <= acc_nxt;
          ma_r  <= {ma_r[ptz_pkg::PROD_W-2:0], 1'b0};
          mb_r  <= mb_r >> 1;
          cnt_r <= ptz_pkg::cnt_t'(cnt_r + 1'b1);
        end
      end
      ST_DIV_CHK: begin
        zres_r <= '0;
        cnt_r  <= '0;
        rem_r  <= ptz_pkg::prod_t'(a_r[ptz_pkg::WIDE_W-1:ptz_pkg::QUO_W]);
        quo_r  <= '0;
        // quotient beyond the root range: saturate through an all-ones radicand
        op_r   <= {1'b0, {ptz_pkg::QUO_W{1'b1}}};
        res_r  <= '0;
        one_r  <= ptz_pkg::rad_t'(1) << (ptz_pkg::RAD_W - 2);
      end
      ST_DIV: begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        a_r   <= {a_r[ptz_pkg::WIDE_W-2:0], 1'b0};
        if (cnt_r == ptz_pkg::cnt_t'(ptz_pkg::DIV_STEPS - 1)) begin
          op_r  <= {1'b0, quo_nxt};
          cnt_r <= '0;
        end else begin
          cnt_r <= ptz_pkg::cnt_t'(cnt_r + 1'b1);
        end
      end
      ST_SQRT: begin
        op_r  <= sge ? (op_r - trial) : op_r;
        res_r <= res_nxt;
        one_r <= one_r >> 2;
        cnt_r <= ptz_pkg::cnt_t'(cnt_r + 1'b1);
        if (cnt_r == ptz_pkg::cnt_t'(ptz_pkg::SQRT_STEPS - 1)) begin
          zres_r <= zval;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          o_now_r  <= x_r;
          o_c1_r   <= c1_r;
          o_r6_r   <= neg6_r ? ptz_pkg::R6_W'(-qu6_r) : qu6_r;
          o_z_r    <= zres_r;
          o_drop_r <= drop_r;
        end
      end
      default: ;
    endcase
  end

  // Register read-back
  always_comb begin
    case (cfg_paddr[3:2])
      ptz_pkg::REG_LAG_1H:   cfg_prdata = ptz_pkg::apb_data_t'(lag1_r);
      ptz_pkg::REG_LAG_6H:   cfg_prdata = ptz_pkg::apb_data_t'(lag6_r);
      ptz_pkg::REG_DROP_THR: cfg_prdata = ptz_pkg::apb_data_t'(thr_r);
      default:               cfg_prdata = '0;
    endcase
  end

  assign cfg_pready          = 1'b1;
  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = ov_r;
  assign out_ch.pressure_now = o_now_r;
  assign out_ch.change_1h    = o_c1_r;
  assign out_ch.rate_6h      = o_r6_r;
  assign out_ch.zscore       = o_z_r;
  assign out_ch.drop_flag    = o_drop_r;

endmodule
`default_nettype wire

/* hdl/ptz_checker.sv */
// Port-level checker for the pressure trend core, bound to the top level
`default_nettype none
`include "pressure_trend_zscore_core_defines.svh"
module ptz_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic change_neg,
  input wire logic drop_flag,
  input wire logic cfg_pready
);

  // hold a result until it is taken
  `PTZ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped")
  // one sample at a time: busy right after an accepted beat
  `PTZ_ASSERT(a_in_busy, in_valid && in_ready |=> !in_ready, "second beat while busy")
  // reset empties the output register
  `PTZ_ASSERT_RST(a_rst_out, !rst_n |=> !out_valid, "result shown after reset")
  // an alert only comes with a falling pressure
  `PTZ_ASSERT(a_drop_neg, out_valid && drop_flag && cfg_pready |-> change_neg,
    "drop flag on a non-negative change")

endmodule

bind pressure_trend_zscore_core ptz_checker u_ptz_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .change_neg (out_ch.change_1h[17]),
  .drop_flag  (out_ch.drop_flag),
  .cfg_pready (cfg_pready)
);
`default_nettype wire

/* test/pressure_trend_zscore_core_tb.sv */
// Self-checking testbench for the pressure trend core: trend, z-score and alert prediction
`timescale 1ns / 100ps
`default_nettype none
module pressure_trend_zscore_core_tb;
  import ptz_pkg::*;

  typedef struct {
    logic [SAMPLE_W-1:0]     pressure_now;
    logic signed [C1_W-1:0]  change_1h;
    logic signed [R6_W-1:0]  rate_6h;
    logic signed [Z_W-1:0]   zscore;
    logic                    drop_flag;
  } trend_result_t;

  // Predictor of the trend outputs plus the queue of results still owed
  class trend_board;
    logic [SAMPLE_W-1:0] ring [DEPTH];
    logic [AW-1:0]       wr_ptr;
    logic [FW-1:0]       held;
    logic [SUM_W-1:0]    win_sum;
    logic [SQS_W-1:0]    win_sq_sum;
    logic [LAG_W-1:0]    lag_short;
    logic [LAG_W-1:0]    lag_long;
    logic [THR_W-1:0]    drop_thr;
    trend_result_t       owed [$];
    int                  mismatches;

    function void reset_state();
      wr_ptr = '0;
      held = '0;
      win_sum = '0;
      win_sq_sum = '0;
      lag_short = LAG_1H_RST;
      lag_long = LAG_6H_RST;
      drop_thr = DROP_THR_RST;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_LAG_1H:   lag_short = val[LAG_W-1:0];
        REG_LAG_6H:   lag_long = val[LAG_W-1:0];
        REG_DROP_THR: drop_thr = val[THR_W-1:0];
        default: ;
      endcase
    endfunction

    // Return 1 and the sample 'back' places behind the newest, if it is held
    function bit look_back(logic [LAG_W-1:0] back, output logic [SAMPLE_W-1:0] val);
      int idx;
      val = '0;
      if (back >= held) return 0;
      idx = (int'(wr_ptr) + 2 * DEPTH - 1 - int'(back)) % DEPTH;
      val = ring[idx];
      return 1;
    endfunction

    // Largest Q8.8 magnitude q with q*q*d <= 65536*dev*dev, exact integers
    function logic signed [Z_W-1:0] window_zscore(logic [SAMPLE_W-1:0] x);
      logic [127:0] n, d, dev, rhs, lhs, nx;
      int lo, hi, mid;
      bit neg;
      n = held;
      if (held < 2) return '0;
      d = n * win_sq_sum - win_sum * win_sum;
      if (d == 0) return '0;
      nx = n * x;
      neg = nx < win_sum;
      dev = neg ? win_sum - nx : nx - win_sum;
      rhs = (dev * dev) << 16;
      lo = 0;
      hi = neg ? 32768 : 32767;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = d * mid * mid;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return neg ? -lo : lo;
    endfunction

    // Advance the window by one sample and owe its result
    function void note_sample(logic [SAMPLE_W-1:0] x);
      trend_result_t r;
      logic [SAMPLE_W-1:0] past, oldest;
      longint diff;
      if (held >= DEPTH) begin
        oldest = ring[wr_ptr];
        win_sum -= oldest;
        win_sq_sum -= SQS_W'(oldest) * SQS_W'(oldest);
        held--;
      end
      ring[wr_ptr] = x;
      wr_ptr++;
      held++;
      win_sum += x;
      win_sq_sum += SQS_W'(x) * SQS_W'(x);
      r.pressure_now = x;
      r.change_1h = '0;
      r.rate_6h = '0;
      if (look_back(lag_short, past)) r.change_1h = longint'(x) - longint'(past);
      if (look_back(lag_long, past)) begin
        diff = longint'(x) - longint'(past);
        r.rate_6h = diff / 6;
      end
      r.zscore = window_zscore(x);
      r.drop_flag = longint'(r.change_1h) < -longint'(drop_thr);
      owed.push_back(r);
    endfunction

    // Compare one delivered result with the oldest owed one
    function void check_result(trend_result_t got);
      trend_result_t exp_r;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: pressure_now=%0d", got.pressure_now);
        return;
      end
      exp_r = owed.pop_front();
      if (got.pressure_now !== exp_r.pressure_now || got.change_1h !== exp_r.change_1h ||
          got.rate_6h !== exp_r.rate_6h || got.zscore !== exp_r.zscore ||
          got.drop_flag !== exp_r.drop_flag) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp now=%0d c1=%0d r6=%0d z=%0d fl=%0b got %0d %0d %0d %0d %0b",
                   exp_r.pressure_now, exp_r.change_1h, exp_r.rate_6h, exp_r.zscore,
                   exp_r.drop_flag, got.pressure_now, got.change_1h, got.rate_6h,
                   got.zscore, got.drop_flag);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic cfg_pready;

  ptz_in_if  in_ch ();
  ptz_out_if out_ch ();

  pressure_trend_zscore_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  trend_board board = new();
  int stall_style;
  int sample_mode;
  logic [SAMPLE_W-1:0] baseline;
  int ready_phase;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Watch both channels at each edge
  always @(posedge clk) begin
    trend_result_t got;
    if (rst_n && in_ch.valid && in_ch.ready) board.note_sample(in_ch.sample);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.pressure_now = out_ch.pressure_now;
      got.change_1h = out_ch.change_1h;
      got.rate_6h = out_ch.rate_6h;
      got.zscore = out_ch.zscore;
      got.drop_flag = out_ch.drop_flag;
      board.check_result(got);
    end
  end

  // Receiver stalls on its own pattern, chosen per phase
  always @(posedge clk) begin
    ready_phase <= ready_phase + 1;
    case (stall_style)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= (ready_phase % 3 != 0);
      default: out_ch.ready <= ((ready_phase / 40) % 2 == 0) || ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    board.set_reg(idx, val);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Hold one beat on the input until accepted; keep valid high within a burst
  task automatic send_sample(logic [SAMPLE_W-1:0] x, bit last_in_burst);
    in_ch.valid <= 1'b1;
    in_ch.sample <= x;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (last_in_burst) in_ch.valid <= 1'b0;
  endtask

  // Drain all owed results, then let the pipeline settle
  task automatic drain();
    while (board.owed.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] next_sample();
    int step;
    case (sample_mode)
      0: begin
        // slow drift with the odd sharp fall
        step = $urandom_range(0, 80) - 40;
        if ($urandom_range(0, 19) == 0) step = -int'($urandom_range(100, 3000));
        if (int'(baseline) + step < 0 || int'(baseline) + step > 131071) step = -step;
        baseline = baseline + step;
        return baseline;
      end
      1: return $urandom_range(0, 131071);
      2: return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071) : baseline;
      default: return $urandom_range(0, 1) ? 17'h1ffff : 17'h0;
    endcase
  endfunction

  task automatic random_phase(int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      for (int i = 0; i < burst; i++) send_sample(next_sample(), i == burst - 1);
      left -= burst;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  task automatic set_regs(logic [31:0] l1, logic [31:0] l6, logic [31:0] thr);
    write_reg(REG_LAG_1H, l1);
    write_reg(REG_LAG_6H, l6);
    write_reg(REG_DROP_THR, thr);
  endtask

  initial begin
    logic [SAMPLE_W-1:0] directed [$];
    board.reset_state();
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    stall_style = 0;
    sample_mode = 0;
    baseline = 17'd101300;
    ready_phase = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: short lags, zero lag, field extremes, flat run, sharp drop
    set_regs(1, 2, 0);
    directed = '{17'd0, 17'd131071, 17'd0, 17'd131071, 17'd131071, 17'd131071,
                 17'd101300, 17'd101300, 17'd101300, 17'd101299, 17'd101000,
                 17'd100000, 17'd65535, 17'd65536, 17'd1, 17'd131070, 17'd0};
    foreach (directed[i]) send_sample(directed[i], i == directed.size() - 1);
    drain();
    set_regs(0, 0, 65535);
    for (int i = 0; i < 4; i++) send_sample(17'h1ffff >> i, i == 3);
    drain();

    // Random phases over a spread of register settings and receiver behaviour
    set_regs(5, 12, 100);
    stall_style = 1;
    sample_mode = 0;
    random_phase(200);
    drain();
    set_regs(60, 360, 150);
    stall_style = 2;
    sample_mode = 1;
    random_phase(150);
    drain();
    set_regs(1023, 1023, 65535);
    stall_style = 3;
    sample_mode = 2;
    random_phase(250);
    drain();
    set_regs(1, 1000, 0);
    stall_style = 0;
    sample_mode = 0;
    random_phase(250);
    drain();
    set_regs($urandom_range(1, 1023), $urandom_range(1, 1023), $urandom_range(0, 65535));
    stall_style = 1;
    sample_mode = 3;
    random_phase(40);
    sample_mode = 0;
    random_phase(160);
    drain();

    if (board.mismatches == 0 && board.owed.size() == 0)
      $display("pressure_trend_zscore_core test passed");
    else
      $display("pressure_trend_zscore_core test failed");
    $finish;
  end

  // Stop a hung run
  initial begin
    #20ms;
    $display("pressure_trend_zscore_core test failed");
    $finish;
  end
endmodule
`default_nettype wire
